@@ hw/rtl/aeskx_pkg.sv @@
// Package for the AES-128 key expansion block.
// Holds the S-box table, round constants and shared types; no dependencies.
package aeskx_pkg;

    localparam int NumCells = 4;
    localparam int NumRounds = 11;
    localparam int HalfW = 64;
    localparam int RoundW = 4;

    typedef logic [31:0] word_t;
    typedef logic [RoundW-1:0] round_t;

    typedef struct packed {
        logic   advance;
        logic   load;
        logic   [7:0] rcon;
    } cell_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [256];
        tbl = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tbl[a];
    endfunction

    function automatic logic [7:0] rcon(input round_t r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HALF0,
        ST_HALF1
    } state_t;

endpackage

@@ hw/rtl/aes128_key_expansion.sv @@
// Top level of the AES-128 key expansion block.
// Uses aeskx_pkg, aeskx_rotsub and aeskx_cell.
//
// Slave channel s_axis takes one key per item: tdata = {key_low, key_high}.
// Master channel m_axis gives 22 items per key, round 0 half 0 first,
// round 10 half 1 last with tlast high. tuser = {half_select, round_index}.
// tdata holds key_half, transposed bytes, first byte in bits 63:56.
// The round key lives in a chain of four word cells; each round every cell
// XORs in its left neighbor's new word, the first cell taking
// RotWord/SubWord/rcon of the last cell, so one round per two output items.
// The output half is selected combinationally from the cell words. The first
// item is offered in the cycle after the key is accepted.
// The next key is accepted in the cycle the last item is taken, so a new
// key is not taken while one is still in expansion. A stalled receiver
// holds the item and freezes the chain. Reset returns the block to idle.
module aes128_key_expansion (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key_high[63:0], key_low[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // key_half[63:0]
    output logic [4:0]   m_axis_tuser,   // round_index[3:0], half_select[4]
    output logic         m_axis_tlast
);
    import aeskx_pkg::*;

    state_t state_reg, state_next;
    round_t round_reg, round_next;
    word_t  w [NumCells];
    word_t  ld [NumCells];
    word_t  head;
    cell_ctrl_t ctrl;
    logic   s_acc, m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    assign ld[0] = s_axis_tdata[63:32];
    assign ld[1] = s_axis_tdata[31:0];
    assign ld[2] = s_axis_tdata[127:96];
    assign ld[3] = s_axis_tdata[95:64];

    aeskx_rotsub u_rotsub (.w(w[NumCells-1]), .rc(ctrl.rcon), .t(head));

    // cell i new = w[i] ^ new(i-1)
    word_t nw [NumCells];
    assign nw[0] = w[0] ^ head;
    for (genvar i = 1; i < NumCells; i++)
    begin : g_new
        assign nw[i] = w[i] ^ nw[i-1];
    end

    for (genvar i = 0; i < NumCells; i++)
    begin : g_cell
        word_t lin;
        assign lin = (i == 0) ? head : nw[(i == 0) ? 0 : i-1];
        aeskx_cell u_cell (
            .clk(clk), .ctrl(ctrl), .load_word(ld[i]), .left_word(lin), .word(w[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        case (state_reg)
            ST_IDLE:
                if (s_acc)
                begin
                    state_next = ST_HALF0;
                    round_next = '0;
                end
            ST_HALF0:
                if (m_acc) state_next = ST_HALF1;
            ST_HALF1:
                if (m_acc)
                begin
                    if (round_reg == round_t'(NumRounds - 1))
                    begin
                        state_next = s_acc ? ST_HALF0 : ST_IDLE;
                        round_next = '0;
                    end
                    else
                    begin
                        state_next = ST_HALF0;
                        round_next = round_reg + round_t'(1);
                    end
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE) ||
                        (state_reg == ST_HALF1 && m_axis_tready &&
                         round_reg == round_t'(NumRounds - 1));
        m_axis_tvalid = (state_reg != ST_IDLE);
        m_axis_tlast = (state_reg == ST_HALF1) && (round_reg == round_t'(NumRounds - 1));
        m_axis_tuser = {(state_reg == ST_HALF1), round_reg};
        ctrl.load = s_acc;
        ctrl.advance = (state_reg == ST_HALF1) && m_acc;
        ctrl.rcon = rcon(round_reg + round_t'(1));
        if (state_reg == ST_HALF1)
        begin
            m_axis_tdata = {w[0][15:8], w[1][15:8], w[2][15:8], w[3][15:8],
                            w[0][7:0],  w[1][7:0],  w[2][7:0],  w[3][7:0]};
        end
        else
        begin
            m_axis_tdata = {w[0][31:24], w[1][31:24], w[2][31:24], w[3][31:24],
                            w[0][23:16], w[1][23:16], w[2][23:16], w[3][23:16]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= round_t'(NumRounds - 1)) else $error("round out of range");
    a_idle_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> round_reg == '0) else $error("idle round");
    a_last_next: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && m_axis_tlast) |=> (round_reg == '0)) else $error("no wrap");
endmodule

@@ hw/rtl/aeskx_cell.sv @@
// One word cell of the key schedule chain.
// Uses aeskx_pkg; XORs in the word from its left neighbor each round.
module aeskx_cell (
    input  logic                  clk,
    input  aeskx_pkg::cell_ctrl_t ctrl,
    input  aeskx_pkg::word_t      load_word,
    input  aeskx_pkg::word_t      left_word,
    output aeskx_pkg::word_t      word
);
    import aeskx_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = load_word;
        end
        else if (ctrl.advance)
        begin
            word_next = word_reg ^ left_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
endmodule

@@ hw/rtl/aeskx_rotsub.sv @@
// Head cell of the chain: RotWord, SubWord and round constant.
// Uses aeskx_pkg for the S-box.
module aeskx_rotsub (
    input  aeskx_pkg::word_t w,
    input  logic [7:0]       rc,
    output aeskx_pkg::word_t t
);
    import aeskx_pkg::*;

    assign t = {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
endmodule
